/* sv/pbp_pkg.sv */
package pbp_pkg;

  localparam int NUM_PROCS_DEF = 4;
  localparam int MAX_TASKS_DEF = 16;

  localparam int CAP_W = 7;
  localparam logic [CAP_W-1:0] FULL_CAP = 7'd100;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_PLACE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_WHOLE,
    ST_LDI_RD,
    ST_LDI_EV,
    ST_J_RD,
    ST_J_EV,
    ST_WI,
    ST_V_RD,
    ST_V_EV
  } pbp_state_t;

endpackage

/* sv/pbp_cap_store.sv */
module pbp_cap_store #(
  parameter int NUM_PROCS = pbp_pkg::NUM_PROCS_DEF,
  localparam int IW = $clog2(NUM_PROCS)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clear,
  input  logic [IW-1:0]            rd_addr,
  input  logic                     wr_en,
  input  logic [IW-1:0]            wr_addr,
  input  logic [pbp_pkg::CAP_W-1:0] wr_data,
  output logic [pbp_pkg::CAP_W-1:0] rd_data
);

  logic [pbp_pkg::CAP_W-1:0] mem [NUM_PROCS];
  logic [NUM_PROCS-1:0]      vld;
  logic [pbp_pkg::CAP_W-1:0] rdata_q;
  logic                      rvld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
    rvld_q  <= vld[rd_addr];
  end

  // an entry not written since the last clear reads as full capacity
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rvld_q ? rdata_q : pbp_pkg::FULL_CAP;

endmodule

/* sv/processor_bandwidth_partitioner_top.sv */
// Processor bandwidth partitioner.
// Request channel (req_valid / req_stall) carries one word per item: kind,
// task_req, demand. A start word (kind 0) sets every processor back to full
// capacity in the cycle it is taken and gives no result. A place word runs a
// worst-fit scan over the processors and either gives the whole demand to one
// processor (one result word) or splits it over the processors ranked by an
// exchange sort (one result word per processor visited, last marks the end).
// Result channel (res_valid / res_stall) is a single output register; the
// next request is taken while the final result word still waits there.
// The capacity and ranking memories have one read port each, so every access
// step is a read state followed by an evaluate state. The scan steps through
// all N = NUM_PROCS processors; a whole placement then adds the ST_WHOLE state;
// a split adds the sort (each rank i loads, compares against every later rank j,
// then writes back) and one access step per processor visited. Receiver
// stalls add to this. While res_stall is high a pending result word holds and
// the sequencer waits on it; no word is lost. After rst all capacities read as
// 100, the output register is empty and the block is ready at once.
module processor_bandwidth_partitioner_top #(
  parameter int NUM_PROCS = pbp_pkg::NUM_PROCS_DEF,
  parameter int MAX_TASKS = pbp_pkg::MAX_TASKS_DEF,
  localparam int IW = $clog2(NUM_PROCS),
  localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic                      kind,
  input  logic [TW-1:0]             task_req,
  input  logic [pbp_pkg::CAP_W-1:0] demand,
  output logic                      res_valid,
  input  logic                      res_stall,
  output logic [TW-1:0]             task_out,
  output logic [IW-1:0]             proc,
  output logic [pbp_pkg::CAP_W-1:0] share,
  output logic                      was_split,
  output logic [pbp_pkg::CAP_W-1:0] unplaced,
  output logic                      last
);

  localparam int CW = pbp_pkg::CAP_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_PROCS - 1);
  localparam logic [IW-1:0] LAST_I   = IW'(NUM_PROCS - 2);

  pbp_pkg::pbp_state_t state, state_next;

  // held item
  logic [TW-1:0] task_q;
  logic [CW-1:0] need;

  // counters: idx walks scan and visits, i and j walk the sort
  logic [IW-1:0] idx, si, sj;

  // worst-fit tracking
  logic          best_vld;
  logic [IW-1:0] best;
  logic [CW-1:0] best_left;
  logic [CW-1:0] best_cap;

  // ranking memory: capacity copy and processor number per rank
  logic [CW-1:0] srt_cap [NUM_PROCS];
  logic [IW-1:0] srt_ord [NUM_PROCS];
  logic [CW-1:0] srt_cap_q;
  logic [IW-1:0] srt_ord_q;
  logic [CW-1:0] held_cap;
  logic [IW-1:0] held_ord;

  logic [IW-1:0] srt_raddr;
  logic          srt_we;
  logic [IW-1:0] srt_waddr;
  logic [CW-1:0] srt_wcap;
  logic [IW-1:0] srt_word;

  // capacity store
  logic          cap_clear;
  logic          cap_we;
  logic [IW-1:0] cap_waddr;
  logic [CW-1:0] cap_wdata;
  logic [CW-1:0] cap_rd;

  logic          req_take;
  logic          out_free;
  logic          emit;
  logic signed [CW+1:0] left;
  logic          better;
  logic [CW-1:0] give;
  logic [CW-1:0] need_left;
  logic          v_done;

  pbp_cap_store #(
    .NUM_PROCS (NUM_PROCS)
  ) u_cap (
    .clk     (clk),
    .rst     (rst),
    .clear   (cap_clear),
    .rd_addr (idx),
    .wr_en   (cap_we),
    .wr_addr (cap_waddr),
    .wr_data (cap_wdata),
    .rd_data (cap_rd)
  );

  assign req_stall = (state != pbp_pkg::ST_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign out_free  = !res_valid || !res_stall;

  // scan: leftover after the demand, kept only when strictly above the best so far
  assign left   = $signed({2'b00, cap_rd}) - $signed({2'b00, need});
  assign better = left > $signed({2'b00, best_left});

  // split visit
  assign give      = (srt_cap_q < need) ? srt_cap_q : need;
  assign need_left = need - give;
  assign v_done    = (need_left == '0) || (idx == LAST_IDX);

  always_comb begin
    state_next = state;
    cap_clear  = 1'b0;
    cap_we     = 1'b0;
    cap_waddr  = best;
    cap_wdata  = best_cap - need;
    srt_raddr  = idx;
    srt_we     = 1'b0;
    srt_waddr  = idx;
    srt_wcap   = cap_rd;
    srt_word   = idx;
    emit       = 1'b0;
    case (state)
      pbp_pkg::ST_IDLE: begin
        if (req_take) begin
          if (kind == pbp_pkg::KIND_START) begin
            cap_clear = 1'b1;
          end else begin
            state_next = pbp_pkg::ST_SCAN_RD;
          end
        end
      end
      pbp_pkg::ST_SCAN_RD: begin
        state_next = pbp_pkg::ST_SCAN_EV;
      end
      pbp_pkg::ST_SCAN_EV: begin
        srt_we = 1'b1;
        if (idx == LAST_IDX) begin
          state_next = (best_vld || better) ? pbp_pkg::ST_WHOLE : pbp_pkg::ST_LDI_RD;
        end else begin
          state_next = pbp_pkg::ST_SCAN_RD;
        end
      end
      pbp_pkg::ST_WHOLE: begin
        if (out_free) begin
          emit       = 1'b1;
          cap_we     = 1'b1;
          state_next = pbp_pkg::ST_IDLE;
        end
      end
      pbp_pkg::ST_LDI_RD: begin
        srt_raddr  = si;
        state_next = pbp_pkg::ST_LDI_EV;
      end
      pbp_pkg::ST_LDI_EV: begin
        state_next = pbp_pkg::ST_J_RD;
      end
      pbp_pkg::ST_J_RD: begin
        srt_raddr  = sj;
        state_next = pbp_pkg::ST_J_EV;
      end
      pbp_pkg::ST_J_EV: begin
        // exchange: the held entry drops to rank j, the larger one is held
        srt_raddr = sj;
        srt_waddr = sj;
        srt_wcap  = held_cap;
        srt_word  = held_ord;
        srt_we    = (held_cap < srt_cap_q);
        state_next = (sj == LAST_IDX) ? pbp_pkg::ST_WI : pbp_pkg::ST_J_RD;
      end
      pbp_pkg::ST_WI: begin
        srt_we    = 1'b1;
        srt_waddr = si;
        srt_wcap  = held_cap;
        srt_word  = held_ord;
        state_next = (si == LAST_I) ? pbp_pkg::ST_V_RD : pbp_pkg::ST_LDI_RD;
      end
      pbp_pkg::ST_V_RD: begin
        state_next = pbp_pkg::ST_V_EV;
      end
      pbp_pkg::ST_V_EV: begin
        // hold the read address so the ranked entry stays while the output waits
        if (out_free) begin
          emit       = 1'b1;
          cap_we     = 1'b1;
          cap_waddr  = srt_ord_q;
          cap_wdata  = srt_cap_q - give;
          state_next = v_done ? pbp_pkg::ST_IDLE : pbp_pkg::ST_V_RD;
        end
      end
      default: begin
        state_next = pbp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pbp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ranking memory
  always_ff @(posedge clk) begin
    if (srt_we) begin
      srt_cap[srt_waddr] <= srt_wcap;
      srt_ord[srt_waddr] <= srt_word;
    end
    srt_cap_q <= srt_cap[srt_raddr];
    srt_ord_q <= srt_ord[srt_raddr];
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    case (state)
      pbp_pkg::ST_IDLE: begin
        task_q    <= task_req;
        need      <= demand;
        idx       <= '0;
        si        <= '0;
        best_vld  <= 1'b0;
        best      <= '0;
        best_left <= '0;
        best_cap  <= '0;
      end
      pbp_pkg::ST_SCAN_EV: begin
        if (better) begin
          best_vld  <= 1'b1;
          best      <= idx;
          best_left <= left[CW-1:0];
          best_cap  <= cap_rd;
        end
        if (idx == LAST_IDX) begin
          idx <= '0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      pbp_pkg::ST_LDI_EV: begin
        held_cap <= srt_cap_q;
        held_ord <= srt_ord_q;
        sj       <= si + 1'b1;
      end
      pbp_pkg::ST_J_EV: begin
        if (held_cap < srt_cap_q) begin
          held_cap <= srt_cap_q;
          held_ord <= srt_ord_q;
        end
        if (sj != LAST_IDX) begin
          sj <= sj + 1'b1;
        end
      end
      pbp_pkg::ST_WI: begin
        si <= si + 1'b1;
      end
      pbp_pkg::ST_V_EV: begin
        if (out_free) begin
          need <= need_left;
          idx  <= idx + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      task_out <= task_q;
      if (state == pbp_pkg::ST_WHOLE) begin
        proc      <= best;
        share     <= need;
        was_split <= 1'b0;
        unplaced  <= '0;
        last      <= 1'b1;
      end else begin
        proc      <= srt_ord_q;
        share     <= give;
        was_split <= 1'b1;
        unplaced  <= v_done ? need_left : '0;
        last      <= v_done;
      end
    end
  end

endmodule
